@@ src/aabb_pkg.sv @@
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int COORD_W       = 20;
    localparam int EXT_W         = 16;
    localparam int IDX_W         = 6;
    localparam int CFG_W         = 7;
    localparam int COUNT_W       = 7;
    localparam int COUNT_MAX     = 127;
    localparam int DIST_W        = COORD_W + 1;
    localparam int DIFF_W        = COORD_W + 2;
    localparam int DEF_MAX_BOXES = 64;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_OVERLAP = 2'd1,
        FUNC_SWEEP   = 2'd2
    } t_func;

    // One stored box as it sits in the table memory.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [EXT_W-1:0]          ex;
        logic [EXT_W-1:0]          ey;
        logic                      trig;
    } t_box;

    // Velocity-independent terms of one box against the query box.
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic signed [DIST_W-1:0]  dx;
        logic signed [DIST_W-1:0]  dy;
        logic [EXT_W-1:0]          lx;
        logic [EXT_W-1:0]          ly;
        logic                      ox;
        logic                      oy;
        logic signed [COORD_W-1:0] clipx;
        logic signed [COORD_W-1:0] clipy;
        logic                      trig;
    } t_geom;

    function automatic logic [DIFF_W-1:0] f_abs(input logic signed [DIFF_W-1:0] v);
        f_abs = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

@@ src/aabb_overlap_and_sweep_resolver_top.sv @@
`timescale 1ns / 1ps
// A load is written to the table in its accept cycle and gives no result. A query walks
// n = min(entries_in_use, MAX_BOXES) entries, one table entry read per cycle, through the read,
// geometry and accumulate stages, then drains and waits for the output register to be free;
// no new item is accepted until its result is captured. Loads are accepted one per cycle.
// Reset (synchronous, active low) clears the control state and entries_in_use;
// the box table is not cleared and holds garbage until loaded.
module aabb_overlap_and_sweep_resolver_top #(
    parameter int MAX_BOXES = aabb_pkg::DEF_MAX_BOXES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [aabb_pkg::CFG_W-1:0]          i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [aabb_pkg::IDX_W-1:0]          i_entry_index,
    input  logic                                i_skip_self,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_center_y,
    input  logic [aabb_pkg::EXT_W-1:0]          i_extent_x,
    input  logic [aabb_pkg::EXT_W-1:0]          i_extent_y,
    input  logic                                i_is_trigger,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_x,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_y,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_any_overlap,
    output logic                                o_solid_hit,
    output logic [aabb_pkg::COUNT_W-1:0]        o_overlap_count,
    output logic [aabb_pkg::IDX_W-1:0]          o_first_hit_index,
    output logic signed [aabb_pkg::COORD_W-1:0] o_vel_x_out,
    output logic signed [aabb_pkg::COORD_W-1:0] o_vel_y_out
);

    import aabb_pkg::*;

    localparam int AW    = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                    r_state;
    t_state                    n_state;

    logic [CFG_W-1:0]          r_entries;
    logic [CNT_W-1:0]          r_limit;
    logic [CNT_W-1:0]          r_addr;
    logic                      r_sweep;
    logic [IDX_W-1:0]          r_self;
    logic                      r_skip;
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;
    logic [EXT_W-1:0]          r_ex;
    logic [EXT_W-1:0]          r_ey;
    logic signed [COORD_W-1:0] r_vx_in;
    logic signed [COORD_W-1:0] r_vy_in;
    logic                      r_p0_valid;
    logic [IDX_W-1:0]          r_p0_idx;

    logic                      r_out_valid;
    logic                      r_any;
    logic                      r_solid;
    logic [COUNT_W-1:0]        r_count;
    logic [IDX_W-1:0]          r_first;
    logic signed [COORD_W-1:0] r_vx_out;
    logic signed [COORD_W-1:0] r_vy_out;

    logic                      w_accept;
    logic                      w_query;
    logic                      w_load;
    logic                      w_in_range;
    logic                      w_issue;
    logic                      w_walking;
    logic                      w_out_free;
    logic [CNT_W-1:0]          w_limit;
    t_box                      w_wbox;
    t_box                      w_rbox;
    t_geom                     w_geom;
    logic [COUNT_W-1:0]        w_count;
    logic [IDX_W-1:0]          w_first;
    logic                      w_solid;
    logic signed [COORD_W-1:0] w_vx;
    logic signed [COORD_W-1:0] w_vy;

    // Accept items only between queries; loads finish in the accept cycle.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = 32'(i_entry_index) < MAX_BOXES;
    assign w_load     = w_accept && (i_func == FUNC_LOAD) && w_in_range;
    assign w_query    = w_accept && (i_func == FUNC_OVERLAP || i_func == FUNC_SWEEP);

    // Clamp the walk length to the table depth.
    assign w_limit = (32'(r_entries) > MAX_BOXES) ? CNT_W'(MAX_BOXES) : CNT_W'(r_entries);

    // Issue one table read per cycle; the caller's own entry is read but dropped.
    assign w_walking = (r_state == S_WALK) && (r_addr < r_limit);
    assign w_issue   = w_walking && !(r_skip && (32'(r_addr) == 32'(r_self)));

    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_wbox.cx   = i_center_x;
    assign w_wbox.cy   = i_center_y;
    assign w_wbox.ex   = i_extent_x;
    assign w_wbox.ey   = i_extent_y;
    assign w_wbox.trig = i_is_trigger;

    aabb_ram #(
        .WIDTH ($bits(t_box)),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (w_wbox),
        .i_re    (w_walking),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rbox)
    );

    aabb_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0_valid),
        .i_idx   (r_p0_idx),
        .i_box   (w_rbox),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .o_geom  (w_geom)
    );

    // An overlap query walks with zero velocity so the moved test equals the plain one.
    aabb_accum u_accum (
        .i_clk   (i_clk),
        .i_start (w_query),
        .i_sweep (r_sweep),
        .i_vx    ((i_func == FUNC_SWEEP) ? i_vel_x : '0),
        .i_vy    ((i_func == FUNC_SWEEP) ? i_vel_y : '0),
        .i_geom  (w_geom),
        .o_count (w_count),
        .o_first (w_first),
        .o_solid (w_solid),
        .o_vx    (w_vx),
        .o_vy    (w_vy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!w_walking) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait until the last entry has left the read and geometry stages.
                if (!r_p0_valid && !w_geom.valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_p0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p0_valid <= w_issue;
            if (i_cfg_we) begin
                r_entries <= i_cfg_data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        r_p0_idx <= IDX_W'(r_addr);

        // Hold the query box for the whole walk.
        if (w_query) begin
            r_limit <= w_limit;
            r_addr  <= '0;
            r_sweep <= (i_func == FUNC_SWEEP);
            r_self  <= i_entry_index;
            r_skip  <= i_skip_self;
            r_qx    <= i_center_x;
            r_qy    <= i_center_y;
            r_ex    <= i_extent_x;
            r_ey    <= i_extent_y;
            r_vx_in <= i_vel_x;
            r_vy_in <= i_vel_y;
        end else if (w_walking) begin
            r_addr <= r_addr + CNT_W'(1);
        end

        // Capture the result once the output register is free.
        if (r_state == S_DONE && w_out_free) begin
            r_any    <= (w_count != '0);
            r_count  <= w_count;
            r_first  <= w_first;
            r_solid  <= r_sweep && w_solid;
            r_vx_out <= r_sweep ? w_vx : r_vx_in;
            r_vy_out <= r_sweep ? w_vy : r_vy_in;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_any_overlap     = r_any;
    assign o_solid_hit       = r_solid;
    assign o_overlap_count   = r_count;
    assign o_first_hit_index = r_first;
    assign o_vel_x_out       = r_vx_out;
    assign o_vel_y_out       = r_vy_out;

endmodule

@@ src/aabb_ram.sv @@
`timescale 1ns / 1ps

module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/aabb_geom.sv @@
`timescale 1ns / 1ps

module aabb_geom (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [aabb_pkg::IDX_W-1:0]         i_idx,
    input  aabb_pkg::t_box                     i_box,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_qx,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_qy,
    input  logic [aabb_pkg::EXT_W-1:0]         i_ex,
    input  logic [aabb_pkg::EXT_W-1:0]         i_ey,
    output aabb_pkg::t_geom                    o_geom
);

    import aabb_pkg::*;

    logic signed [DIST_W-1:0]  w_dx;
    logic signed [DIST_W-1:0]  w_dy;
    logic [EXT_W:0]            w_sx;
    logic [EXT_W:0]            w_sy;
    logic [EXT_W-1:0]          w_lx;
    logic [EXT_W-1:0]          w_ly;
    logic signed [COORD_W-1:0] w_clipx;
    logic signed [COORD_W-1:0] w_clipy;
    t_geom                     r_geom;

    // Stop at contact: pull the distance in by the limit, toward zero side.
    function automatic logic signed [COORD_W-1:0] f_clip(
        input logic signed [DIST_W-1:0] d,
        input logic [EXT_W-1:0]         lim
    );
        logic signed [DIFF_W-1:0] v;
        logic                     pos;
        pos = !d[DIST_W-1] && (d != '0);
        v = pos ? DIFF_W'(d) - DIFF_W'(lim) : DIFF_W'(d) + DIFF_W'(lim);
        if (v[DIFF_W-1:COORD_W-1] == '0 || v[DIFF_W-1:COORD_W-1] == '1) begin
            f_clip = v[COORD_W-1:0];
        end else if (v[DIFF_W-1]) begin
            f_clip = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            f_clip = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    assign w_dx    = DIST_W'(i_box.cx) - DIST_W'(i_qx);
    assign w_dy    = DIST_W'(i_box.cy) - DIST_W'(i_qy);
    assign w_sx    = (EXT_W+1)'(i_ex) + (EXT_W+1)'(i_box.ex);
    assign w_sy    = (EXT_W+1)'(i_ey) + (EXT_W+1)'(i_box.ey);
    assign w_lx    = w_sx[EXT_W:1];
    assign w_ly    = w_sy[EXT_W:1];
    assign w_clipx = f_clip(w_dx, w_lx);
    assign w_clipy = f_clip(w_dy, w_ly);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.valid <= 1'b0;
        end else begin
            r_geom.valid <= i_valid;
        end
        r_geom.idx   <= i_idx;
        r_geom.dx    <= w_dx;
        r_geom.dy    <= w_dy;
        r_geom.lx    <= w_lx;
        r_geom.ly    <= w_ly;
        r_geom.ox    <= f_abs(DIFF_W'(w_dx)) < DIFF_W'(w_lx);
        r_geom.oy    <= f_abs(DIFF_W'(w_dy)) < DIFF_W'(w_ly);
        r_geom.clipx <= w_clipx;
        r_geom.clipy <= w_clipy;
        r_geom.trig  <= i_box.trig;
    end

    assign o_geom = r_geom;

endmodule

@@ src/aabb_accum.sv @@
`timescale 1ns / 1ps

module aabb_accum (
    input  logic                                i_clk,
    input  logic                                i_start,
    input  logic                                i_sweep,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vx,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vy,
    input  aabb_pkg::t_geom                     i_geom,
    output logic [aabb_pkg::COUNT_W-1:0]        o_count,
    output logic [aabb_pkg::IDX_W-1:0]          o_first,
    output logic                                o_solid,
    output logic signed [aabb_pkg::COORD_W-1:0] o_vx,
    output logic signed [aabb_pkg::COORD_W-1:0] o_vy
);

    import aabb_pkg::*;

    logic [COUNT_W-1:0]        r_count;
    logic [IDX_W-1:0]          r_first;
    logic                      r_solid;
    logic signed [COORD_W-1:0] r_vx;
    logic signed [COORD_W-1:0] r_vy;
    logic                      w_ax;
    logic                      w_ay;
    logic                      w_hit;

    // Moved-box tests against the velocity carried so far.
    assign w_ax  = f_abs(DIFF_W'(i_geom.dx) - DIFF_W'(r_vx)) < DIFF_W'(i_geom.lx);
    assign w_ay  = f_abs(DIFF_W'(i_geom.dy) - DIFF_W'(r_vy)) < DIFF_W'(i_geom.ly);
    assign w_hit = i_geom.valid && w_ax && w_ay;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count <= '0;
            r_first <= '0;
            r_solid <= 1'b0;
            r_vx    <= i_vx;
            r_vy    <= i_vy;
        end else if (w_hit) begin
            if (r_count == '0) begin
                r_first <= i_geom.idx;
            end
            if (r_count != COUNT_W'(COUNT_MAX)) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_sweep && !i_geom.trig) begin
                r_solid <= 1'b1;
                if (i_geom.ox && w_ay) begin
                    r_vy <= i_geom.clipy;
                end else if (w_ax && i_geom.oy) begin
                    r_vx <= i_geom.clipx;
                end
            end
        end
    end

    assign o_count = r_count;
    assign o_first = r_first;
    assign o_solid = r_solid;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;

endmodule

@@ dv/aabb_resolver_checker.sv @@
`timescale 1ns / 1ps

module aabb_resolver_checker #(
    parameter int MAX_BOXES = aabb_pkg::DEF_MAX_BOXES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aabb_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [aabb_pkg::IDX_W-1:0]          i_entry_index,
    input  logic                                i_skip_self,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_center_y,
    input  logic [aabb_pkg::EXT_W-1:0]          i_extent_x,
    input  logic [aabb_pkg::EXT_W-1:0]          i_extent_y,
    input  logic                                i_is_trigger,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_x,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_y,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_any_overlap,
    input  logic                                i_solid_hit,
    input  logic [aabb_pkg::COUNT_W-1:0]        i_overlap_count,
    input  logic [aabb_pkg::IDX_W-1:0]          i_first_hit_index,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_x_out,
    input  logic signed [aabb_pkg::COORD_W-1:0] i_vel_y_out,
    output int                                  o_pending,
    output int                                  o_errors
);
    import aabb_pkg::*;

    typedef struct {
        logic                      any;
        logic                      solid;
        logic [COUNT_W-1:0]        count;
        logic [IDX_W-1:0]          first;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } t_hit_report;

    // shadow copy of the box table and the walk length register
    longint           box_cx   [MAX_BOXES];
    longint           box_cy   [MAX_BOXES];
    longint           box_ex   [MAX_BOXES];
    longint           box_ey   [MAX_BOXES];
    logic             box_trig [MAX_BOXES];
    logic [CFG_W-1:0] walk_len_cfg;
    t_hit_report      expected_reports[$];

    initial begin
        o_pending    = 0;
        o_errors     = 0;
        walk_len_cfg = '0;
        for (int i = 0; i < MAX_BOXES; i++) begin
            box_cx[i]   = 0;
            box_cy[i]   = 0;
            box_ex[i]   = 0;
            box_ey[i]   = 0;
            box_trig[i] = 1'b0;
        end
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // saturate to the signed coordinate range
    function automatic longint clamp_coord(input longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic t_hit_report resolve_query(input logic [1:0] func, input int self_idx,
                                                  input logic skip, input longint qx,
                                                  input longint qy, input longint ex,
                                                  input longint ey, input longint vx0,
                                                  input longint vy0);
        t_hit_report r;
        longint      vx, vy, dx, dy, lx, ly;
        int          n, hits, first;
        logic        sweep, hit, solid, vert, horz;
        sweep = (func == FUNC_SWEEP);
        vx    = vx0;
        vy    = vy0;
        hits  = 0;
        first = 0;
        solid = 1'b0;
        n     = (walk_len_cfg > MAX_BOXES) ? MAX_BOXES : int'(walk_len_cfg);
        for (int i = 0; i < n; i++) begin
            if (skip && i == self_idx)
                continue;
            dx = box_cx[i] - qx;
            dy = box_cy[i] - qy;
            lx = (ex + box_ex[i]) >> 1;
            ly = (ey + box_ey[i]) >> 1;
            if (sweep)
                hit = mag(dx - vx) < lx && mag(dy - vy) < ly;
            else
                hit = mag(dx) < lx && mag(dy) < ly;
            if (!hit)
                continue;
            if (hits == 0)
                first = i;
            if (hits < COUNT_MAX)
                hits++;
            if (sweep && !box_trig[i]) begin
                // clip vertical first, horizontal only if vertical alone is clear
                vert = mag(dx) < lx && mag(dy - vy) < ly;
                horz = mag(dx - vx) < lx && mag(dy) < ly;
                if (vert)
                    vy = clamp_coord(dy > 0 ? dy - ly : dy + ly);
                else if (horz)
                    vx = clamp_coord(dx > 0 ? dx - lx : dx + lx);
                solid = 1'b1;
            end
        end
        r.any   = (hits != 0);
        r.solid = solid;
        r.count = COUNT_W'(hits);
        r.first = IDX_W'(first);
        r.vx    = COORD_W'(vx);
        r.vy    = COORD_W'(vy);
        return r;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hit_report want;
        if (!i_rst_n) begin
            walk_len_cfg = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we)
                walk_len_cfg = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with none expected, actual count %0d", $time,
                             i_overlap_count);
                    o_errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("any_overlap", longint'(want.any), longint'(i_any_overlap));
                    check_field("solid_hit", longint'(want.solid), longint'(i_solid_hit));
                    check_field("overlap_count", longint'(want.count),
                                longint'(i_overlap_count));
                    check_field("first_hit_index", longint'(want.first),
                                longint'(i_first_hit_index));
                    check_field("vel_x_out", longint'(want.vx), longint'(i_vel_x_out));
                    check_field("vel_y_out", longint'(want.vy), longint'(i_vel_y_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == FUNC_LOAD) begin
                    if (int'(i_entry_index) < MAX_BOXES) begin
                        box_cx[i_entry_index]   = longint'(i_center_x);
                        box_cy[i_entry_index]   = longint'(i_center_y);
                        box_ex[i_entry_index]   = longint'(i_extent_x);
                        box_ey[i_entry_index]   = longint'(i_extent_y);
                        box_trig[i_entry_index] = i_is_trigger;
                    end
                end else if (i_func == FUNC_OVERLAP || i_func == FUNC_SWEEP) begin
                    expected_reports.insert(expected_reports.size(),
                                            resolve_query(i_func, int'(i_entry_index),
                                                          i_skip_self,
                                                          longint'(i_center_x),
                                                          longint'(i_center_y),
                                                          longint'(i_extent_x),
                                                          longint'(i_extent_y),
                                                          longint'(i_vel_x),
                                                          longint'(i_vel_y)));
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

@@ dv/tb_aabb_overlap_and_sweep_resolver_top.sv @@
`timescale 1ns / 1ps

module tb_aabb_overlap_and_sweep_resolver_top;
    import aabb_pkg::*;

    // func code 3 is not decoded by the block: it must be swallowed silently
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 70;
    localparam int         CFG_SETTLE      = 8;
    localparam int         TAIL_CYCLES     = 80;

    typedef struct {
        logic [1:0]                func;
        logic [IDX_W-1:0]          entry_index;
        logic                      skip_self;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [EXT_W-1:0]          ex;
        logic [EXT_W-1:0]          ey;
        logic                      trig;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } t_query_item;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CFG_W-1:0]          cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic [1:0]                func        = FUNC_LOAD;
    logic [IDX_W-1:0]          entry_index = '0;
    logic                      skip_self   = 1'b0;
    logic signed [COORD_W-1:0] center_x    = '0;
    logic signed [COORD_W-1:0] center_y    = '0;
    logic [EXT_W-1:0]          extent_x    = '0;
    logic [EXT_W-1:0]          extent_y    = '0;
    logic                      is_trigger  = 1'b0;
    logic signed [COORD_W-1:0] vel_x       = '0;
    logic signed [COORD_W-1:0] vel_y       = '0;
    logic                      out_ready   = 1'b0;

    wire                       in_ready;
    wire                       out_valid;
    wire                       any_overlap;
    wire                       solid_hit;
    wire [COUNT_W-1:0]         overlap_count;
    wire [IDX_W-1:0]           first_hit_index;
    wire signed [COORD_W-1:0]  vel_x_out;
    wire signed [COORD_W-1:0]  vel_y_out;

    int pending;
    int errors;
    int idle_pct  = 0;   // chance per cycle that the sender holds off
    int stall_pct = 0;   // chance per cycle that the receiver stalls
    int walk_n    = 0;   // entries a query walks under the current register value
    int base_x, base_y;  // center of the box cluster so that queries find hits

    // walk length per random phase: full table, tiny, saturating, single, odd sizes
    int walk_setting[PHASES] = '{64, 5, 127, 1, 64, 100, 33, 2};

    always #2 clk = ~clk;

    // drive receiver back-pressure on the falling edge
    always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

    aabb_overlap_and_sweep_resolver_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_func            (func),
        .i_entry_index     (entry_index),
        .i_skip_self       (skip_self),
        .i_center_x        (center_x),
        .i_center_y        (center_y),
        .i_extent_x        (extent_x),
        .i_extent_y        (extent_y),
        .i_is_trigger      (is_trigger),
        .i_vel_x           (vel_x),
        .i_vel_y           (vel_y),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_any_overlap     (any_overlap),
        .o_solid_hit       (solid_hit),
        .o_overlap_count   (overlap_count),
        .o_first_hit_index (first_hit_index),
        .o_vel_x_out       (vel_x_out),
        .o_vel_y_out       (vel_y_out)
    );

    aabb_resolver_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_func            (func),
        .i_entry_index     (entry_index),
        .i_skip_self       (skip_self),
        .i_center_x        (center_x),
        .i_center_y        (center_y),
        .i_extent_x        (extent_x),
        .i_extent_y        (extent_y),
        .i_is_trigger      (is_trigger),
        .i_vel_x           (vel_x),
        .i_vel_y           (vel_y),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_any_overlap     (any_overlap),
        .i_solid_hit       (solid_hit),
        .i_overlap_count   (overlap_count),
        .i_first_hit_index (first_hit_index),
        .i_vel_x_out       (vel_x_out),
        .i_vel_y_out       (vel_y_out),
        .o_pending         (pending),
        .o_errors          (errors)
    );

    // end the run if the block hangs; far above the slowest legal run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_query_item box_item(input logic [1:0] f, input int idx, input int skip,
                                             input int cx, input int cy, input int ex,
                                             input int ey, input int trig, input int vx,
                                             input int vy);
        t_query_item it;
        it.func        = f;
        it.entry_index = IDX_W'(idx);
        it.skip_self   = skip[0];
        it.cx          = COORD_W'(cx);
        it.cy          = COORD_W'(cy);
        it.ex          = EXT_W'(ex);
        it.ey          = EXT_W'(ey);
        it.trig        = trig[0];
        it.vx          = COORD_W'(vx);
        it.vy          = COORD_W'(vy);
        return it;
    endfunction

    // uniform offset in [-span, span]
    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Build one random item. Most items sit in a tight cluster so that queries
    // hit and clip; a tenth are raw noise over the full field widths.
    function automatic t_query_item make_item(input int walk);
        t_query_item it;
        int          roll;
        roll    = $urandom_range(99);
        it.func = (roll < 30) ? FUNC_LOAD : (roll < 55) ? FUNC_OVERLAP :
                  (roll < 95) ? FUNC_SWEEP : FUNC_UNUSED;
        // aim most indexes at the walked part of the table
        if (walk > 0 && $urandom_range(99) < 75)
            it.entry_index = IDX_W'($urandom_range(walk - 1));
        else
            it.entry_index = IDX_W'($urandom_range(63));
        it.skip_self = 1'($urandom_range(1));
        it.trig      = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 10) begin
            it.cx = COORD_W'($urandom);
            it.cy = COORD_W'($urandom);
            it.ex = EXT_W'($urandom);
            it.ey = EXT_W'($urandom);
            it.vx = COORD_W'($urandom);
            it.vy = COORD_W'($urandom);
        end else begin
            it.cx = COORD_W'(base_x + jitter(1500));
            it.cy = COORD_W'(base_y + jitter(1500));
            it.ex = EXT_W'($urandom_range(2000));
            it.ey = EXT_W'($urandom_range(2000));
            it.vx = COORD_W'(jitter(2500));
            it.vy = COORD_W'(jitter(2500));
        end
        return it;
    endfunction

    // Present one item: hold off at random, then hold valid and payload until taken.
    task automatic send_item(input t_query_item it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= it.func;
        entry_index <= it.entry_index;
        skip_self   <= it.skip_self;
        center_x    <= it.cx;
        center_y    <= it.cy;
        extent_x    <= it.ex;
        extent_y    <= it.ey;
        is_trigger  <= it.trig;
        vel_x       <= it.vx;
        vel_y       <= it.vy;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write the walk length only once the block is idle; a trailing load or
    // unused code may still be in flight, so let the CFG_SETTLE settle time pass first.
    task automatic set_walk_len(input int value);
        wait_drained();
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
        walk_n = (value > DEF_MAX_BOXES) ? DEF_MAX_BOXES : value;
    endtask

    initial begin
        t_query_item it;
        base_x = int'($urandom_range(800000)) - 400000;
        base_y = int'($urandom_range(800000)) - 400000;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Walk length is zero out of reset: a query finds nothing
        // and echoes its velocity; then the unused func code with all ones.
        send_item(box_item(FUNC_SWEEP, 63, 1, -524288, 524287, 65535, 0, 0, 524287, -524288));
        send_item(box_item(FUNC_UNUSED, 63, 1, -1, -1, 65535, 65535, 1, -1, -1));

        // a small scene: solid, trigger, zero-size, odd sizes and the corners
        send_item(box_item(FUNC_LOAD, 0, 0, 0, 0, 32, 32, 0, 0, 0));
        send_item(box_item(FUNC_LOAD, 1, 0, 100, 0, 32, 32, 1, 0, 0));
        send_item(box_item(FUNC_LOAD, 2, 0, 0, 200, 64, 16, 0, 0, 0));
        send_item(box_item(FUNC_LOAD, 3, 0, 524287, 524287, 65535, 65535, 0, 0, 0));
        send_item(box_item(FUNC_LOAD, 4, 0, -524288, -524288, 65535, 65535, 1, 0, 0));
        send_item(box_item(FUNC_LOAD, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(box_item(FUNC_LOAD, 6, 0, 40, 40, 33, 33, 0, 0, 0));
        send_item(box_item(FUNC_LOAD, 7, 0, -300, 50, 100, 100, 0, 0, 0));
        set_walk_len(8);

        // overlap: plain, with the caller skipped, touching edges, both corners
        send_item(box_item(FUNC_OVERLAP, 0, 0, 0, 0, 32, 32, 0, 77, -77));
        send_item(box_item(FUNC_OVERLAP, 0, 1, 0, 0, 32, 32, 0, 0, 0));
        send_item(box_item(FUNC_OVERLAP, 0, 0, 32, 0, 32, 32, 0, 0, 0));
        send_item(box_item(FUNC_OVERLAP, 4, 0, -524288, -524288, 65535, 65535, 0, 0, 0));
        send_item(box_item(FUNC_OVERLAP, 3, 1, 524287, 524287, 65535, 65535, 0, 0, 0));
        // sweep: vertical clip both ways, horizontal clip, diagonal-only contact,
        // trigger passthrough, skipped caller, extreme velocity
        send_item(box_item(FUNC_SWEEP, 9, 0, 0, -100, 32, 32, 0, 0, 100));
        send_item(box_item(FUNC_SWEEP, 9, 0, 0, 100, 32, 32, 0, 0, -100));
        send_item(box_item(FUNC_SWEEP, 9, 0, -100, 0, 32, 32, 0, 100, 0));
        send_item(box_item(FUNC_SWEEP, 9, 0, -100, -100, 32, 32, 0, 100, 100));
        send_item(box_item(FUNC_SWEEP, 9, 0, 100, -100, 32, 32, 0, 0, 100));
        send_item(box_item(FUNC_SWEEP, 7, 1, -300, 50, 100, 100, 0, 0, 0));
        send_item(box_item(FUNC_SWEEP, 0, 0, 0, 0, 65535, 65535, 0, 524287, -524288));

        // Fill the whole table so that any walk length reads written entries only.
        for (int i = 0; i < DEF_MAX_BOXES; i++) begin
            it             = make_item(DEF_MAX_BOXES);
            it.func        = FUNC_LOAD;
            it.entry_index = IDX_W'(i);
            send_item(it);
        end

        // Random phases: rotate walk length and idling pattern together.
        for (int p = 0; p < PHASES; p++) begin
            set_walk_len(walk_setting[p]);
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 77;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 77;
                end
                default: begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // now and then hold the sender until the block has drained
                if ($urandom_range(99) < 3)
                    wait_drained();
                send_item(make_item(walk_n));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
